FILE: sv/waveform_trace_delta_renderer_top_macros.svh
// ---------------------------------------------------------------------------
// waveform trace delta renderer assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef WAVEFORM_TRACE_DELTA_RENDERER_TOP_MACROS_SVH
`define WAVEFORM_TRACE_DELTA_RENDERER_TOP_MACROS_SVH

// checked only outside reset
`define WTDR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define WTDR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/wtdr_pkg.sv
// ---------------------------------------------------------------------------
// wtdr_pkg
// constants, types and mapping functions of the trace delta renderer
// ---------------------------------------------------------------------------
`default_nettype none

package wtdr_pkg;

   localparam int FRAME_LEN = 256;
   localparam int POS_W     = $clog2(FRAME_LEN);
   localparam int CNT_W     = $clog2(FRAME_LEN + 1);
   localparam int SCREEN_W  = 160;
   localparam int DVD_W     = $clog2(FRAME_LEN * SCREEN_W);
   localparam int STEP_W    = $clog2(DVD_W + 1);

   localparam int SAMPLE_W  = 10;
   localparam int ZOOM_W    = 3;
   localparam int X_W       = 8;
   localparam int Y_W       = 7;
   localparam int COLOUR_W  = 16;
   localparam int PROD_W    = 17;
   localparam int ADC_SHIFT = 10;

   localparam logic [COLOUR_W-1:0] TRACE_COLOUR = 16'h6b39;
   localparam logic [COLOUR_W-1:0] ERASE_COLOUR = 16'h0000;
   localparam logic [Y_W-1:0]      Y_BASE       = 7'd111;
   localparam logic [ZOOM_W-1:0]   ZOOM_UNITY   = 3'd1;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [POS_W-1:0]    addr;
      logic [SAMPLE_W-1:0] wr_data;
   } store_req_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [X_W-1:0] quotient;
   } div_rsp_type;

   // zoom of zero behaves as unity
   function automatic logic [ZOOM_W-1:0] eff_scale(input logic [ZOOM_W-1:0] z);
      return (z == '0) ? ZOOM_UNITY : z;
   endfunction

   // number of pairs inside the zoomed span
   function automatic logic [CNT_W-1:0] span_limit(input logic [ZOOM_W-1:0] s);
      logic [CNT_W-1:0] r;
      unique case (s)
         3'd2:    r = CNT_W'((FRAME_LEN - 1) / 2);
         3'd3:    r = CNT_W'((FRAME_LEN - 1) / 3);
         3'd4:    r = CNT_W'((FRAME_LEN - 1) / 4);
         3'd5:    r = CNT_W'((FRAME_LEN - 1) / 5);
         3'd6:    r = CNT_W'((FRAME_LEN - 1) / 6);
         3'd7:    r = CNT_W'((FRAME_LEN - 1) / 7);
         default: r = CNT_W'(FRAME_LEN - 1);
      endcase
      return r;
   endfunction

   // shown sample span
   function automatic logic [CNT_W-1:0] frame_part(input logic [ZOOM_W-1:0] s);
      logic [CNT_W-1:0] r;
      unique case (s)
         3'd2:    r = CNT_W'(FRAME_LEN / 2);
         3'd3:    r = CNT_W'(FRAME_LEN / 3);
         3'd4:    r = CNT_W'(FRAME_LEN / 4);
         3'd5:    r = CNT_W'(FRAME_LEN / 5);
         3'd6:    r = CNT_W'(FRAME_LEN / 6);
         3'd7:    r = CNT_W'(FRAME_LEN / 7);
         default: r = CNT_W'(FRAME_LEN);
      endcase
      return r;
   endfunction

   // row = 111 - v*88/1023, division by 2^10-1 through shift and add
   function automatic logic [Y_W-1:0] map_y(input logic [SAMPLE_W-1:0] v);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] qsum;
      prod = (PROD_W'(v) << 6) + (PROD_W'(v) << 4) + (PROD_W'(v) << 3);
      qsum = prod + (prod >> ADC_SHIFT) + PROD_W'(1);
      return Y_BASE - Y_W'(qsum >> ADC_SHIFT);
   endfunction

endpackage

`default_nettype wire

FILE: sv/wtdr_divider.sv
// ---------------------------------------------------------------------------
// wtdr_divider
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module wtdr_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wtdr_pkg::div_req_type div_req,
   output      wtdr_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [wtdr_pkg::STEP_W-1:0]  count_ff, count_in;
   logic [wtdr_pkg::DVD_W-1:0]   acc_ff, acc_in;
   logic [wtdr_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [wtdr_pkg::CNT_W-1:0]   den_ff, den_in;

   logic [wtdr_pkg::CNT_W:0]     trial;
   logic [wtdr_pkg::CNT_W:0]     diff;
   logic                         fits;

   always_comb begin
      trial = {rem_ff, acc_ff[wtdr_pkg::DVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;

      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         acc_in   = div_req.dividend;
         rem_in   = '0;
         den_in   = div_req.divisor;
      end else if (busy_ff) begin
         acc_in   = {acc_ff[wtdr_pkg::DVD_W-2:0], fits};
         rem_in   = fits ? diff[wtdr_pkg::CNT_W-1:0] : trial[wtdr_pkg::CNT_W-1:0];
         count_in = count_ff + wtdr_pkg::STEP_W'(1);
         if (count_ff == wtdr_pkg::STEP_W'(wtdr_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = acc_ff[wtdr_pkg::X_W-1:0];

endmodule

`default_nettype wire

FILE: sv/wtdr_frame_store.sv
// ---------------------------------------------------------------------------
// wtdr_frame_store
// previous frame memory with per-entry valid bits, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module wtdr_frame_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wtdr_pkg::store_req_type       store_req,
   output      logic [wtdr_pkg::SAMPLE_W-1:0] rd_data
);

   logic [wtdr_pkg::SAMPLE_W-1:0]  frame_mem [wtdr_pkg::FRAME_LEN];
   logic [wtdr_pkg::SAMPLE_W-1:0]  rd_data_ff;
   logic                           rd_valid_ff, rd_valid_in;
   logic [wtdr_pkg::FRAME_LEN-1:0] valid_ff, valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (store_req.wr_en) begin
         valid_in[store_req.addr] = 1'b1;
      end
      rd_valid_in = store_req.rd_en ? valid_ff[store_req.addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         frame_mem[store_req.addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= frame_mem[store_req.addr];
      end
   end

   // entries never written read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: sv/waveform_trace_delta_renderer_top.sv
// an item with segments shows its erase transfer once the divider has given its
// start and end columns, the draw transfer once the erase has been taken
// a new item is taken only back in idle; with segments the pace is
// set by the shared serial divider running once for each segment end column
// reset: synchronous; frame store valid bits clear at once, no clearing pass
// ---------------------------------------------------------------------------
// waveform_trace_delta_renderer_top
// frame delta renderer: compares each sample pair against the stored frame
// and emits erase and draw line segments
// ---------------------------------------------------------------------------
`default_nettype none

module waveform_trace_delta_renderer_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [wtdr_pkg::ZOOM_W-1:0]   csr_write_data,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [wtdr_pkg::SAMPLE_W-1:0] req_sample_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_is_erase,
   output      logic [wtdr_pkg::X_W-1:0]      rsp_x_start,
   output      logic [wtdr_pkg::Y_W-1:0]      rsp_y_start,
   output      logic [wtdr_pkg::X_W-1:0]      rsp_x_end,
   output      logic [wtdr_pkg::Y_W-1:0]      rsp_y_end,
   output      logic [wtdr_pkg::COLOUR_W-1:0] rsp_pixel_colour,
   output      logic                          rsp_last_of_run
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_DIV1  = 6'b000100,
      ST_DIV2  = 6'b001000,
      ST_ERASE = 6'b010000,
      ST_DRAW  = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   logic [wtdr_pkg::ZOOM_W-1:0]    zoom_ff, zoom_in;
   logic [wtdr_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [wtdr_pkg::SAMPLE_W-1:0]  prior_new_ff, prior_new_in;
   logic [wtdr_pkg::SAMPLE_W-1:0]  prior_old_ff, prior_old_in;
   logic [wtdr_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [wtdr_pkg::POS_W-1:0]     idx_ff, idx_in;
   logic [wtdr_pkg::CNT_W-1:0]     den_ff, den_in;
   logic [wtdr_pkg::X_W-1:0]       x_start_ff, x_start_in;
   logic [wtdr_pkg::X_W-1:0]       x_end_ff, x_end_in;
   logic [wtdr_pkg::Y_W-1:0]       y_old_a_ff, y_old_a_in;
   logic [wtdr_pkg::Y_W-1:0]       y_old_b_ff, y_old_b_in;
   logic [wtdr_pkg::Y_W-1:0]       y_new_a_ff, y_new_a_in;
   logic [wtdr_pkg::Y_W-1:0]       y_new_b_ff, y_new_b_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_is_erase_ff, rsp_is_erase_in;
   logic [wtdr_pkg::X_W-1:0]       rsp_x_start_ff, rsp_x_start_in;
   logic [wtdr_pkg::Y_W-1:0]       rsp_y_start_ff, rsp_y_start_in;
   logic [wtdr_pkg::X_W-1:0]       rsp_x_end_ff, rsp_x_end_in;
   logic [wtdr_pkg::Y_W-1:0]       rsp_y_end_ff, rsp_y_end_in;
   logic [wtdr_pkg::COLOUR_W-1:0]  rsp_colour_ff, rsp_colour_in;
   logic                           rsp_last_ff, rsp_last_in;

   wtdr_pkg::store_req_type        store_req;
   wtdr_pkg::div_req_type          div_req;
   wtdr_pkg::div_rsp_type          div_rsp;
   logic [wtdr_pkg::SAMPLE_W-1:0]  old_sample;

   logic [wtdr_pkg::ZOOM_W-1:0]    scale;
   logic [wtdr_pkg::POS_W-1:0]     idx;
   logic [wtdr_pkg::CNT_W-1:0]     part;
   logic [wtdr_pkg::CNT_W-1:0]     den_c;
   logic                           den_zero;
   logic                           in_span;
   logic                           changed;
   logic                           emit;
   logic                           out_free;

   wtdr_frame_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (old_sample)
   );

   wtdr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      scale    = wtdr_pkg::eff_scale(zoom_ff);
      idx      = pos_ff - wtdr_pkg::POS_W'(1);
      part     = wtdr_pkg::frame_part(scale);
      den_c    = part - wtdr_pkg::CNT_W'(2);
      den_zero = part <= wtdr_pkg::CNT_W'(2);
      in_span  = (pos_ff != '0) &&
                 (wtdr_pkg::CNT_W'(idx) < wtdr_pkg::span_limit(scale));
      changed  = (prior_new_ff != sample_ff) || (prior_old_ff != old_sample);
      emit     = in_span && changed;
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      zoom_in      = csr_write_enable ? csr_write_data : zoom_ff;
      pos_in       = pos_ff;
      prior_new_in = prior_new_ff;
      prior_old_in = prior_old_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      den_in       = den_ff;
      x_start_in   = x_start_ff;
      x_end_in     = x_end_ff;
      y_old_a_in   = y_old_a_ff;
      y_old_b_in   = y_old_b_ff;
      y_new_a_in   = y_new_a_ff;
      y_new_b_in   = y_new_b_ff;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_erase_in = rsp_is_erase_ff;
      rsp_x_start_in  = rsp_x_start_ff;
      rsp_y_start_in  = rsp_y_start_ff;
      rsp_x_end_in    = rsp_x_end_ff;
      rsp_y_end_in    = rsp_y_end_ff;
      rsp_colour_in   = rsp_colour_ff;
      rsp_last_in     = rsp_last_ff;

      store_req      = '0;
      store_req.addr = pos_ff;
      div_req        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               store_req.rd_en = 1'b1;
               sample_in       = req_sample_value;
               state_in        = ST_CHECK;
            end
         end
         ST_CHECK: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_data = sample_ff;
            prior_new_in      = sample_ff;
            prior_old_in      = old_sample;
            pos_in            = (pos_ff == wtdr_pkg::POS_W'(wtdr_pkg::FRAME_LEN - 1)) ?
                                '0 : pos_ff + wtdr_pkg::POS_W'(1);
            idx_in            = idx;
            den_in            = den_c;
            y_old_a_in        = wtdr_pkg::map_y(prior_old_ff);
            y_old_b_in        = wtdr_pkg::map_y(old_sample);
            y_new_a_in        = wtdr_pkg::map_y(prior_new_ff);
            y_new_b_in        = wtdr_pkg::map_y(sample_ff);
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (den_zero) begin
               x_start_in = '0;
               x_end_in   = '0;
               state_in   = ST_ERASE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = wtdr_pkg::DVD_W'(idx) *
                                  wtdr_pkg::DVD_W'(wtdr_pkg::SCREEN_W);
               div_req.divisor  = den_c;
               state_in         = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               x_start_in       = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = (wtdr_pkg::DVD_W'(idx_ff) + wtdr_pkg::DVD_W'(1)) *
                                  wtdr_pkg::DVD_W'(wtdr_pkg::SCREEN_W);
               div_req.divisor  = den_ff;
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               x_end_in = div_rsp.quotient;
               state_in = ST_ERASE;
            end
         end
         ST_ERASE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_erase_in = 1'b1;
               rsp_x_start_in  = x_start_ff;
               rsp_y_start_in  = y_old_a_ff;
               rsp_x_end_in    = x_end_ff;
               rsp_y_end_in    = y_old_b_ff;
               rsp_colour_in   = wtdr_pkg::ERASE_COLOUR;
               rsp_last_in     = 1'b0;
               state_in        = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_erase_in = 1'b0;
               rsp_x_start_in  = x_start_ff;
               rsp_y_start_in  = y_new_a_ff;
               rsp_x_end_in    = x_end_ff;
               rsp_y_end_in    = y_new_b_ff;
               rsp_colour_in   = wtdr_pkg::TRACE_COLOUR;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zoom_ff      <= wtdr_pkg::ZOOM_UNITY;
         pos_ff       <= '0;
         prior_new_ff <= '0;
         prior_old_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zoom_ff      <= zoom_in;
         pos_ff       <= pos_in;
         prior_new_ff <= prior_new_in;
         prior_old_ff <= prior_old_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff       <= sample_in;
      idx_ff          <= idx_in;
      den_ff          <= den_in;
      x_start_ff      <= x_start_in;
      x_end_ff        <= x_end_in;
      y_old_a_ff      <= y_old_a_in;
      y_old_b_ff      <= y_old_b_in;
      y_new_a_ff      <= y_new_a_in;
      y_new_b_ff      <= y_new_b_in;
      rsp_is_erase_ff <= rsp_is_erase_in;
      rsp_x_start_ff  <= rsp_x_start_in;
      rsp_y_start_ff  <= rsp_y_start_in;
      rsp_x_end_ff    <= rsp_x_end_in;
      rsp_y_end_ff    <= rsp_y_end_in;
      rsp_colour_ff   <= rsp_colour_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_erase     = rsp_is_erase_ff;
   assign rsp_x_start      = rsp_x_start_ff;
   assign rsp_y_start      = rsp_y_start_ff;
   assign rsp_x_end        = rsp_x_end_ff;
   assign rsp_y_end        = rsp_y_end_ff;
   assign rsp_pixel_colour = rsp_colour_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: sv/wtdr_checker.sv
// ---------------------------------------------------------------------------
// wtdr_checker
// port-level checks of the trace delta renderer, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "waveform_trace_delta_renderer_top_macros.svh"

module wtdr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_is_erase,
   input wire logic [wtdr_pkg::X_W-1:0]      rsp_x_start,
   input wire logic [wtdr_pkg::Y_W-1:0]      rsp_y_start
);

   // no result survives reset
   `WTDR_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

   // busy right after an input transfer
   `WTDR_ASSERT(a_busy_after_req, req_valid && !req_stall |=> req_stall, "not busy after transfer")

   // an erase transfer is followed by its draw, never another erase
   `WTDR_ASSERT(a_erase_then_draw, rsp_valid && !rsp_stall && rsp_is_erase |=> !(rsp_valid && rsp_is_erase), "erase not followed by draw")

   // stalled result holds
   `WTDR_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_erase) && $stable(rsp_x_start) && $stable(rsp_y_start), "stalled result changed")

endmodule

bind waveform_trace_delta_renderer_top wtdr_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_is_erase (rsp_is_erase),
   .rsp_x_start  (rsp_x_start),
   .rsp_y_start  (rsp_y_start)
);

`default_nettype wire
